/* hw/rtl/quadratic_ramp_setpoint_limiter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic ramp setpoint limiter
// Concurrent checks sampled on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_RAMP_SETPOINT_LIMITER_MACROS_SVH
`define QUADRATIC_RAMP_SETPOINT_LIMITER_MACROS_SVH

// same-cycle implication
`define QRSL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrsl: same-cycle check failed");

// next-cycle implication
`define QRSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrsl: next-cycle check failed");

`endif

/* hw/rtl/qrsl_pkg.sv */
// ----------------------------------------------------------------------------
// qrsl_pkg
// Shared types and register codes of the quadratic ramp setpoint limiter.
// ----------------------------------------------------------------------------
package qrsl_pkg;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_UP   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_DOWN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DECEL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_UP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_DOWN = 3'd5;

  // one strobe per datapath step
  typedef struct packed {
    logic load;
    logic diff;
    logic zone;
    logic mul;
    logic sum;
    logic root;
    logic limit;
    logic clamp_pos;
    logic clamp_neg;
    logic select;
    logic sat;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic root_last;
  } status_t;

endpackage

/* hw/rtl/qrsl_datapath.sv */
// ----------------------------------------------------------------------------
// qrsl_datapath
// Config registers, ramp state, bit-serial isqrt and the limit/clamp logic.
// ----------------------------------------------------------------------------
module qrsl_datapath #(
  parameter int POS_WIDTH  = 32,
  parameter int RATE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [qrsl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic signed [RATE_WIDTH:0]        cfg_data,
  input  logic signed [POS_WIDTH-1:0]       target_position,
  input  qrsl_pkg::cmd_t                    cmd,
  output qrsl_pkg::status_t                 status,
  output logic signed [POS_WIDTH-1:0]       setpoint,
  output logic                              done_res
);
  import qrsl_pkg::*;

  localparam int MW  = ((POS_WIDTH > RATE_WIDTH) ? POS_WIDTH : RATE_WIDTH) + 4;
  localparam int XW  = 2 * RATE_WIDTH + 2;
  localparam int NIT = RATE_WIDTH + 1;
  localparam int CW  = $clog2(NIT);

  localparam logic signed [MW-1:0] PMAX =
    {{(MW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [MW-1:0] PMIN =
    {{(MW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};

  // config
  logic [RATE_WIDTH-1:0]        speed_up, speed_down, accel, decel, brake_up;
  logic signed [RATE_WIDTH:0]   brake_down;
  // ramp state
  logic signed [POS_WIDTH-1:0]  last_setpoint;
  logic signed [POS_WIDTH:0]    last_speed;
  // work registers
  logic signed [POS_WIDTH-1:0]  tgt;
  logic signed [POS_WIDTH:0]    delta;
  logic                         zone_up, zone_dn;
  logic [RATE_WIDTH-1:0]        mag, a_sel;
  logic [2*RATE_WIDTH-1:0]      prod_sq, prod_da;
  logic [XW-1:0]                rem, root, bitm;
  logic [CW-1:0]                cnt;
  logic signed [MW-1:0]         vpos, vneg, nxt;

  // wide views
  logic signed [MW-1:0] acc_w, dec_w, spu_w, spd_w, thu_w, thd_w;
  logic signed [MW-1:0] prev_w, last_w, dist_w, tgt_w, dist_abs;
  logic signed [MW-1:0] root_w, half_w;
  logic signed [MW-1:0] c_in, c_diff, c_step, c_out;
  logic signed [MW-1:0] sel_sum, sat_w, speed_w;
  logic                 sel_hi, sel_lo;
  logic [XW-1:0]        trial;

  always_comb begin
    acc_w    = $signed(MW'(accel));
    dec_w    = $signed(MW'(decel));
    spu_w    = $signed(MW'(speed_up));
    spd_w    = $signed(MW'(speed_down));
    thu_w    = $signed(MW'(brake_up));
    thd_w    = MW'(brake_down);
    prev_w   = MW'(last_speed);
    last_w   = MW'(last_setpoint);
    dist_w   = MW'(delta);
    tgt_w    = MW'(tgt);
    dist_abs = (dist_w < 0) ? -dist_w : dist_w;

    trial    = root + bitm;
    root_w   = $signed(MW'(root[NIT-1:0]));
    half_w   = $signed(MW'(a_sel >> 1));

    // shared acceleration clamp for both speed limits
    c_in   = cmd.clamp_pos ? vpos : vneg;
    c_diff = c_in - prev_w;
    c_step = (c_diff > 0) ? acc_w : -dec_w;
    if (((accel != '0) && (c_diff > acc_w)) || ((decel != '0) && (c_diff < -dec_w))) begin
      c_out = prev_w + c_step;
    end else begin
      c_out = c_in;
    end

    sel_hi  = dist_w > vpos;
    sel_lo  = dist_w < vneg;
    sel_sum = last_w + (sel_hi ? vpos : vneg);

    if (nxt > PMAX) begin
      sat_w = PMAX;
    end else if (nxt < PMIN) begin
      sat_w = PMIN;
    end else begin
      sat_w = nxt;
    end

    speed_w = nxt - last_w;
  end

  assign status.root_last = (cnt == CW'(NIT - 1));

  // config and ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_up      <= '0;
      speed_down    <= '0;
      accel         <= '0;
      decel         <= '0;
      brake_up      <= '0;
      brake_down    <= '0;
      last_setpoint <= '0;
      last_speed    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SPEED_UP:   speed_up   <= cfg_data[RATE_WIDTH-1:0];
          REG_SPEED_DOWN: speed_down <= cfg_data[RATE_WIDTH-1:0];
          REG_ACCEL:      accel      <= cfg_data[RATE_WIDTH-1:0];
          REG_DECEL:      decel      <= cfg_data[RATE_WIDTH-1:0];
          REG_BRAKE_UP:   brake_up   <= cfg_data[RATE_WIDTH-1:0];
          REG_BRAKE_DOWN: brake_down <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        last_setpoint <= nxt[POS_WIDTH-1:0];
        last_speed    <= speed_w[POS_WIDTH:0];
      end
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt <= target_position;
    end
    if (cmd.diff) begin
      delta <= (POS_WIDTH+1)'(tgt) - (POS_WIDTH+1)'(last_setpoint);
    end
    if (cmd.zone) begin
      zone_up <= (dist_w > 0) && (decel != '0) && (dist_w < thu_w);
      zone_dn <= (dist_w < 0) && (accel != '0) && (dist_w > thd_w);
      mag     <= dist_abs[RATE_WIDTH-1:0];
      a_sel   <= (dist_w > 0) ? decel : accel;
    end
    if (cmd.mul) begin
      prod_sq <= a_sel * a_sel;
      prod_da <= mag * a_sel;
    end
    if (cmd.sum) begin
      rem  <= XW'(prod_sq >> 2) + XW'({prod_da, 1'b0});
      root <= '0;
      bitm <= {2'b01, {(XW-2){1'b0}}};
      cnt  <= '0;
    end
    if (cmd.root) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitm;
      end else begin
        root <= root >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + CW'(1);
    end
    if (cmd.limit) begin
      vpos <= zone_up ? (root_w - half_w) : spu_w;
      vneg <= zone_dn ? -(root_w + half_w) : -spd_w;
    end
    if (cmd.clamp_pos) begin
      vpos <= c_out;
    end
    if (cmd.clamp_neg) begin
      vneg <= c_out;
    end
    if (cmd.select) begin
      nxt <= (sel_hi || sel_lo) ? sel_sum : tgt_w;
    end
    if (cmd.sat) begin
      nxt <= sat_w;
    end
    if (cmd.commit) begin
      setpoint <= nxt[POS_WIDTH-1:0];
      done_res <= (nxt[POS_WIDTH-1:0] == tgt) && (nxt[POS_WIDTH-1:0] == last_setpoint);
    end
  end

endmodule

/* hw/rtl/qrsl_ctrl.sv */
// ----------------------------------------------------------------------------
// qrsl_ctrl
// Sequencer for one item at a time and the result valid flag.
// ----------------------------------------------------------------------------
module qrsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  qrsl_pkg::status_t  status,
  output qrsl_pkg::cmd_t     cmd
);
  import qrsl_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_DIFF      = 12'b000000000010,
    S_ZONE      = 12'b000000000100,
    S_MUL       = 12'b000000001000,
    S_SUM       = 12'b000000010000,
    S_ROOT      = 12'b000000100000,
    S_LIMIT     = 12'b000001000000,
    S_CLAMP_POS = 12'b000010000000,
    S_CLAMP_NEG = 12'b000100000000,
    S_SELECT    = 12'b001000000000,
    S_SAT       = 12'b010000000000,
    S_COMMIT    = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_ZONE;
      end
      S_ZONE: begin
        cmd.zone   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (status.root_last) begin
          state_next = S_LIMIT;
        end
      end
      S_LIMIT: begin
        cmd.limit  = 1'b1;
        state_next = S_CLAMP_POS;
      end
      S_CLAMP_POS: begin
        cmd.clamp_pos = 1'b1;
        state_next    = S_CLAMP_NEG;
      end
      S_CLAMP_NEG: begin
        cmd.clamp_neg = 1'b1;
        state_next    = S_SELECT;
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/quadratic_ramp_setpoint_limiter.sv */
// ----------------------------------------------------------------------------
// quadratic_ramp_setpoint_limiter: trapezoidal ramp with sqrt braking curve
// Takes one item at a time: a new item is accepted only after the last one commits.
// Sync reset: idle, result flag low, config registers and ramp state zero.
// ----------------------------------------------------------------------------
`include "quadratic_ramp_setpoint_limiter_macros.svh"

// Per item: distance to the last setpoint, braking-zone test, the two
// products a*a and |d|*a, the radicand, RATE_WIDTH+1 isqrt steps (one root
// bit a cycle), speed limits, accel/decel clamp of each limit through one
// shared unit, step selection, saturation to the position range, commit.
// The result sits in an output register; the next item is taken while it
// still waits, and commit only holds off if the previous result is unread.
// Config writes are always taken (ready tied high); writes are expected
// only while the block is idle. Indexes beyond the list are dropped.
module quadratic_ramp_setpoint_limiter #(
  parameter int POS_WIDTH  = 32,
  parameter int RATE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // item in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [POS_WIDTH-1:0]       target_position,
  // result out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [POS_WIDTH-1:0]       setpoint,
  output logic                              done_res,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qrsl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic signed [RATE_WIDTH:0]        cfg_data
);
  import qrsl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register file never back-pressures
  assign cfg_ready = 1'b1;

  qrsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  qrsl_datapath #(
    .POS_WIDTH  (POS_WIDTH),
    .RATE_WIDTH (RATE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .target_position (target_position),
    .cmd             (cmd),
    .status          (status),
    .setpoint        (setpoint),
    .done_res        (done_res)
  );

  // an accepted item keeps the input side busy
  `QRSL_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)
  // a result is never written over one still waiting
  `QRSL_ASSERT_IMPL(a_commit_free, clk, rst, cmd.commit, !out_valid || !out_stall)
  // commit always raises the result flag
  `QRSL_ASSERT_NEXT(a_commit_valid, clk, rst, cmd.commit, out_valid)
  // limits only after the last root step
  `QRSL_ASSERT_IMPL(a_root_complete, clk, rst, cmd.limit, $past(cmd.root) && $past(status.root_last))

endmodule
